// ----- sv/swes_pkg.sv -----
// Shared types and constants of the sync word event scanner.
`default_nettype none
package swes_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OffsetW = 40;
  localparam int unsigned NumberW = 10;
  localparam int unsigned PosW    = 38;
  localparam int unsigned FrameW  = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 38;

  localparam logic [DataW-1:0]   SyncMarker  = 32'hAA55_F151;
  localparam logic [FrameW-1:0]  FrameReset  = 16'd1;
  localparam logic [PosW-1:0]    LimitReset  = {PosW{1'b1}};

  localparam logic [CfgIdxW-1:0] CfgFrameWords = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgWordLimit  = 1'b1;

  localparam int unsigned MaxEventsDefault  = 1024;
  localparam int unsigned QueueDepthDefault = 2;

  typedef struct packed {
    logic restart;
    logic marker;
  } swes_item_t;

  typedef struct packed {
    logic [OffsetW-1:0] marker_addr;
    logic [NumberW-1:0] number;
  } swes_event_t;

endpackage
`default_nettype wire

// ----- sv/swes_fifo.sv -----
// Small register queue; Depth is a power of two, at least 2.
`default_nettype none
module swes_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end
endmodule
`default_nettype wire

// ----- sv/swes_front.sv -----
// Front stage: accepts words and classifies them as restart or marker.
`default_nettype none
module swes_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic                     req_type_i,
  input  logic [swes_pkg::DataW-1:0] data_word_i,
  output logic                     item_push_o,
  output swes_pkg::swes_item_t     item_o,
  input  logic                     item_full_i
);
  import swes_pkg::*;

  logic       valid_q;
  swes_item_t item_q;
  logic       accept;

  assign full_o      = valid_q && item_full_i;
  assign accept      = push_i && !full_o;
  assign item_push_o = valid_q;
  assign item_o      = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (!item_full_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.restart <= req_type_i;
      item_q.marker  <= (data_word_i == SyncMarker);
    end
  end
endmodule
`default_nettype wire

// ----- sv/swes_back.sv -----
// Back stage: position, skip and event counters, config registers, event words.
`default_nettype none
module swes_back #(
  parameter int unsigned MaxEvents = swes_pkg::MaxEventsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [swes_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [swes_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         item_empty_i,
  input  swes_pkg::swes_item_t         item_i,
  output logic                         item_pop_o,
  input  logic                         evt_full_i,
  output logic                         evt_push_o,
  output swes_pkg::swes_event_t        evt_o
);
  import swes_pkg::*;

  localparam int unsigned CntW = $clog2(MaxEvents + 1);

  logic [FrameW-1:0] frame_q;
  logic [PosW-1:0]   limit_q;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [FrameW-1:0] skip_q, skip_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              emit;
  logic [31:0]       cnt_wide;

  assign item_pop_o = !item_empty_i && !evt_full_i;
  assign evt_push_o = item_pop_o && emit;
  assign cnt_wide   = 32'(cnt_q);
  assign evt_o.marker_addr = {pos_q, 2'b00};
  assign evt_o.number      = cnt_wide[NumberW-1:0];

  always_comb begin
    pos_d  = pos_q;
    skip_d = skip_q;
    cnt_d  = cnt_q;
    emit   = 1'b0;
    if (item_i.restart) begin
      pos_d  = '0;
      skip_d = '0;
      cnt_d  = '0;
    end else if (cnt_q != CntW'(MaxEvents) && pos_q < limit_q) begin
      pos_d = pos_q + PosW'(1);
      if (skip_q != '0) begin
        skip_d = skip_q - FrameW'(1);
      end else if (item_i.marker) begin
        emit   = 1'b1;
        cnt_d  = cnt_q + CntW'(1);
        skip_d = (frame_q > FrameW'(1)) ? frame_q - FrameW'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FrameReset;
      limit_q <= LimitReset;
      pos_q   <= '0;
      skip_q  <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgFrameWords: frame_q <= cfg_data_i[FrameW-1:0];
          CfgWordLimit:  limit_q <= cfg_data_i[PosW-1:0];
          default: ;
        endcase
      end
      if (item_pop_o) begin
        pos_q  <= pos_d;
        skip_q <= skip_d;
        cnt_q  <= cnt_d;
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/sync_word_event_scanner.sv -----
// Top level of the sync word event scanner.
// Scans aligned 32-bit stream words for the marker 0xAA55F151 and queues one
// event word (marker byte offset, event number) per hit, then skips the rest
// of the frame. Sustains one word per clock while the event queue has room:
// the front register does the marker compare, a short queue feeds the back
// stage whose counters update once per word, and an output queue holds
// events until popped. Config writes are always ready.
`default_nettype none
module sync_word_event_scanner #(
  parameter int unsigned MaxEvents  = swes_pkg::MaxEventsDefault,
  parameter int unsigned QueueDepth = swes_pkg::QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         req_type_i,
  input  logic [swes_pkg::DataW-1:0]   data_word_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [swes_pkg::OffsetW-1:0] event_byte_offset_o,
  output logic [swes_pkg::NumberW-1:0] event_number_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [swes_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [swes_pkg::CfgW-1:0]    cfg_data_i
);
  import swes_pkg::*;

  logic        item_push, item_full, item_pop, item_empty;
  swes_item_t  item_in, item_out;
  logic        evt_push, evt_full;
  swes_event_t evt_in, evt_out;

  assign cfg_ready_o         = 1'b1;
  assign event_byte_offset_o = evt_out.marker_addr;
  assign event_number_o      = evt_out.number;

  swes_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_type_i  (req_type_i),
    .data_word_i (data_word_i),
    .item_push_o (item_push),
    .item_o      (item_in),
    .item_full_i (item_full)
  );

  swes_fifo #(
    .Width ($bits(swes_item_t)),
    .Depth (QueueDepth)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_push),
    .wdata_i (item_in),
    .full_o  (item_full),
    .pop_i   (item_pop),
    .rdata_o (item_out),
    .empty_o (item_empty)
  );

  swes_back #(
    .MaxEvents (MaxEvents)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_empty_i (item_empty),
    .item_i       (item_out),
    .item_pop_o   (item_pop),
    .evt_full_i   (evt_full),
    .evt_push_o   (evt_push),
    .evt_o        (evt_in)
  );

  swes_fifo #(
    .Width ($bits(swes_event_t)),
    .Depth (QueueDepth)
  ) u_evt_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evt_push),
    .wdata_i (evt_in),
    .full_o  (evt_full),
    .pop_i   (pop),
    .rdata_o (evt_out),
    .empty_o (empty)
  );
endmodule
`default_nettype wire

// ----- tb/swes_checker.sv -----
// Checker for the sync word event scanner: predicts event words and compares popped ones.
module swes_checker #(
  parameter int unsigned MaxEvents = swes_pkg::MaxEventsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  input  logic                         full,
  input  logic                         req_type_i,
  input  logic [swes_pkg::DataW-1:0]   data_word_i,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [swes_pkg::OffsetW-1:0] event_byte_offset_o,
  input  logic [swes_pkg::NumberW-1:0] event_number_o,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [swes_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [swes_pkg::CfgW-1:0]    cfg_data_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  events_due_o
);
  import swes_pkg::*;

  logic [FrameW-1:0] frame_words_q;
  logic [PosW-1:0]   word_limit_q;
  logic [PosW-1:0]   word_pos_q;
  logic [FrameW-1:0] skip_left_q;
  int unsigned       events_found_q;
  swes_event_t       events_due[$];

  assign events_due_o = events_due.size();

  always @(posedge clk_i or negedge rst_ni) begin : scan_model
    swes_event_t want;
    swes_event_t hit;
    logic [PosW-1:0] at;
    if (!rst_ni) begin
      frame_words_q    = FrameReset;
      word_limit_q     = LimitReset;
      word_pos_q       = '0;
      skip_left_q      = '0;
      events_found_q   = 0;
      mismatch_count_o = 0;
      events_due.delete();
    end else begin
      // results first: an event popped now is never from a word pushed now
      if (pop && !empty) begin
        if (events_due.size() == 0) begin
          $error("unexpected event word: offset %0h number %0d",
                 event_byte_offset_o, event_number_o);
          mismatch_count_o++;
        end else begin
          want = events_due.pop_front();
          if (event_byte_offset_o !== want.marker_addr) begin
            $error("event_byte_offset: expected %0h, got %0h",
                   want.marker_addr, event_byte_offset_o);
            mismatch_count_o++;
          end
          if (event_number_o !== want.number) begin
            $error("event_number: expected %0d, got %0d", want.number, event_number_o);
            mismatch_count_o++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgFrameWords: frame_words_q = cfg_data_i[FrameW-1:0];
          CfgWordLimit:  word_limit_q  = cfg_data_i[PosW-1:0];
          default: ;
        endcase
      end

      if (push && !full) begin
        if (req_type_i) begin
          word_pos_q     = '0;
          skip_left_q    = '0;
          events_found_q = 0;
        end else if (events_found_q < MaxEvents && word_pos_q < word_limit_q) begin
          at         = word_pos_q;
          word_pos_q = word_pos_q + 1'b1;
          if (skip_left_q != 0) begin
            skip_left_q = skip_left_q - 1'b1;
          end else if (data_word_i == SyncMarker) begin
            hit.marker_addr = {at, 2'b00};
            hit.number      = events_found_q[NumberW-1:0];
            events_due.push_back(hit);
            events_found_q++;
            skip_left_q = (frame_words_q > 1) ? frame_words_q - 1'b1 : '0;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sync_word_event_scanner_tb.sv -----
// Testbench top for the sync word event scanner: stimulus, handshake timing and verdict.
module sync_word_event_scanner_tb;
  import swes_pkg::*;

  localparam int unsigned MaxEvents    = MaxEventsDefault;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned RandomWords  = 420;
  localparam logic        ReqData      = 1'b0;
  localparam logic        ReqRestart   = 1'b1;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               push        = 1'b0;
  logic               full;
  logic               req_type_i  = ReqData;
  logic [DataW-1:0]   data_word_i = '0;
  logic               empty;
  logic               pop         = 1'b0;
  logic [OffsetW-1:0] event_byte_offset_o;
  logic [NumberW-1:0] event_number_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CfgFrameWords;
  logic [CfgW-1:0]    cfg_data_i  = '0;

  int unsigned mismatch_count;
  int unsigned events_due;
  bit          quiet       = 1'b0;
  bit          rx_hold_req = 1'b0;
  bit          hold_taken  = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned stall_cycles = 0;

  sync_word_event_scanner #(
    .MaxEvents(MaxEvents)
  ) dut (
    .clk_i, .rst_ni, .push, .full, .req_type_i, .data_word_i, .empty, .pop,
    .event_byte_offset_o, .event_number_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i
  );

  swes_checker #(
    .MaxEvents(MaxEvents)
  ) checker_i (
    .clk_i, .rst_ni, .push, .full, .req_type_i, .data_word_i, .empty, .pop,
    .event_byte_offset_o, .event_number_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i,
    .mismatch_count_o(mismatch_count),
    .events_due_o(events_due)
  );

  always #4 clk_i = ~clk_i;

  // event word receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (rx_hold_req && !hold_taken) begin
      pop        <= 1'b0;
      hold_taken <= 1'b1;
      hold_left  <= HoldCycles;
    end else if (hold_left != 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      pop <= quiet || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [DataW-1:0] stream_word(input int unsigned marker_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < marker_pct) return SyncMarker;
    if (roll < marker_pct + 10) return SyncMarker ^ (32'd1 << $urandom_range(31));
    return $urandom;
  endfunction

  task automatic send_item(input logic req, input logic [DataW-1:0] word);
    while (!quiet && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    req_type_i  <= req;
    data_word_i <= word;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop offering words until every predicted event word is out and the pipe is empty
  task automatic settle();
    push <= 1'b0;
    @(negedge clk_i);
    while (events_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    int unsigned marks;
    int unsigned sent;
    int unsigned burst;
    int unsigned seg;
    logic [CfgW-1:0] limit_val;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults: adjacent markers, field extremes, near misses, restart
    send_item(ReqData, SyncMarker);
    send_item(ReqData, SyncMarker);
    send_item(ReqData, '0);
    send_item(ReqData, '1);
    send_item(ReqData, SyncMarker ^ 32'h0000_0001);
    send_item(ReqData, SyncMarker ^ 32'h8000_0000);
    send_item(ReqRestart, '1);
    send_item(ReqData, SyncMarker);

    // zero frame acts as one
    settle();
    write_reg(CfgFrameWords, '0);
    send_item(ReqData, SyncMarker);
    send_item(ReqData, SyncMarker);

    // marker inside a skipped frame is not compared
    settle();
    write_reg(CfgFrameWords, 38'd3);
    send_item(ReqData, SyncMarker);
    send_item(ReqData, SyncMarker);
    send_item(ReqData, SyncMarker);
    send_item(ReqData, SyncMarker);

    // shrink frame while a skip is running
    settle();
    write_reg(CfgFrameWords, 38'd5);
    send_item(ReqData, SyncMarker);
    settle();
    write_reg(CfgFrameWords, 38'd1);
    repeat (5) send_item(ReqData, SyncMarker);

    // word limit zero, then three
    settle();
    write_reg(CfgWordLimit, '0);
    send_item(ReqRestart, '0);
    send_item(ReqData, SyncMarker);
    settle();
    write_reg(CfgWordLimit, 38'd3);
    send_item(ReqData, SyncMarker);
    send_item(ReqData, '0);
    send_item(ReqData, SyncMarker);
    send_item(ReqData, SyncMarker);

    // widest frame, cut short by restart
    settle();
    write_reg(CfgFrameWords, 38'd65535);
    write_reg(CfgWordLimit, LimitReset);
    send_item(ReqRestart, '0);
    send_item(ReqData, SyncMarker);
    send_item(ReqData, SyncMarker);
    send_item(ReqRestart, '0);
    send_item(ReqData, SyncMarker);

    // fill the event table; receiver holds off at the start so the input backs up
    settle();
    write_reg(CfgFrameWords, 38'd1);
    send_item(ReqRestart, '0);
    rx_hold_req <= 1'b1;
    marks = 0;
    while (marks < MaxEvents + 6) begin
      quiet <= (marks >= 200 && marks < 500);
      if ($urandom_range(99) < 95) begin
        send_item(ReqData, SyncMarker);
        marks++;
      end else begin
        send_item(ReqData, $urandom);
      end
    end
    quiet <= 1'b0;

    sent = 0;
    seg  = 0;
    while (sent < RandomWords) begin
      settle();
      if ($urandom_range(99) < 60) begin
        case ($urandom_range(9))
          0:       write_reg(CfgFrameWords, '0);
          1:       write_reg(CfgFrameWords, 38'd65535);
          default: write_reg(CfgFrameWords, CfgW'($urandom_range(6, 1)));
        endcase
      end
      if ($urandom_range(99) < 40) begin
        case ($urandom_range(5))
          0:       limit_val = '0;
          1:       limit_val = LimitReset;
          2:       limit_val = CfgW'({$urandom, $urandom});
          default: limit_val = CfgW'($urandom_range(60, 5));
        endcase
        write_reg(CfgWordLimit, limit_val);
      end
      quiet <= (seg == 4);
      if ($urandom_range(99) < 70) send_item(ReqRestart, $urandom);
      burst = $urandom_range(60, 20);
      repeat (burst) begin
        if ($urandom_range(99) < 2) send_item(ReqRestart, $urandom);
        else send_item(ReqData, stream_word(30));
      end
      sent += burst;
      seg++;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/swes_pkg.sv
sv/swes_fifo.sv
sv/swes_front.sv
sv/swes_back.sv
sv/sync_word_event_scanner.sv
tb/swes_checker.sv
tb/sync_word_event_scanner_tb.sv
